// ----- rtl/grm_pkg.sv -----
// Shared constants, types and register codes of the grid ray marcher.
`timescale 1ns / 1ps
package grm_pkg;

	// Block constants
	localparam int MAX_STEPS  = 1050;
	localparam int CELL_SIZE  = 50;
	localparam int MAP_DIM    = 10;
	localparam int ANGLE_BITS = 12;

	// Field widths
	localparam int ANG_W   = ANGLE_BITS;
	localparam int COL_W   = 6;
	localparam int DIST_W  = 11;
	localparam int SHADE_W = 8;
	localparam int POS_W   = 17;
	localparam int MAP_LO_W = 64;
	localparam int MAP_HI_W = 36;
	localparam int MAP_BITS = MAP_LO_W + MAP_HI_W;
	localparam int DATA_W  = 64;

	// Configuration register codes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH = 2'd3;

	// Sine evaluation
	localparam int QTR    = 1 << (ANGLE_BITS - 2);
	localparam int Q_W    = ANGLE_BITS - 1;
	localparam int WAVE_W = 17;
	localparam int X_SHIFT = 17 - ANGLE_BITS;
	localparam int DIR_W  = 16;

	// Marching in s.14 fixed point
	localparam int FX_SHIFT = 6;
	localparam int POS_FX_W = POS_W + FX_SHIFT;
	localparam int SPAN     = CELL_SIZE << 14;
	localparam int SPAN_W   = $clog2(SPAN) + 1;
	localparam int REM_W    = ((POS_FX_W > SPAN_W) ? POS_FX_W : SPAN_W) + 1;
	localparam int CELL_W   =
		$clog2((1 << POS_FX_W) / SPAN + (MAX_STEPS * 16384) / SPAN + 2) + 1;
	localparam int CX_W      = $clog2(MAP_DIM);
	localparam int MAP_IDX_W = $clog2(MAP_BITS);
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	// One ray after direction lookup
	typedef struct packed {
		logic signed [DIR_W-1:0] dx;
		logic signed [DIR_W-1:0] dy;
		logic [COL_W-1:0]        column;
	} ray_t;

	// Register contents seen by the marcher
	typedef struct packed {
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [MAP_BITS-1:0] map;
	} cfg_t;

endpackage

// ----- rtl/grm_front.sv -----
// Front end: accepts rays and evaluates the sin/cos direction vector.
`timescale 1ns / 1ps
module grm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [grm_pkg::ANG_W-1:0]           ray_angle,
	input  logic [grm_pkg::COL_W-1:0]           column,
	output logic                                ray_valid,
	input  logic                                ray_ready,
	output grm_pkg::ray_t                       ray
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	localparam logic [1:0] PH_X2 = 2'd0;
	localparam logic [1:0] PH_T1 = 2'd1;
	localparam logic [1:0] PH_T2 = 2'd2;
	localparam logic [1:0] PH_R  = 2'd3;

	localparam int WW = grm_pkg::WAVE_W;
	localparam int AW = grm_pkg::ANG_W;
	localparam int QW = grm_pkg::Q_W;
	localparam int DW = grm_pkg::DIR_W;

	localparam logic [WW-1:0] C2320  = WW'(2320);
	localparam logic [WW-1:0] C21024 = WW'(21024);
	localparam logic [WW-1:0] C51472 = WW'(51472);
	localparam logic [AW-1:0] QTR_A  = AW'(grm_pkg::QTR);
	localparam logic [QW-1:0] QTR_Q  = QW'(grm_pkg::QTR);

	logic [1:0]             st_q;
	logic [1:0]             ph_q;
	logic [WW-1:0]          x_q   [2];
	logic [WW-1:0]          x2_q  [2];
	logic [WW-1:0]          t_q   [2];
	logic                   neg_q [2];
	logic signed [DW-1:0]   dir_q [2];
	logic [grm_pkg::COL_W-1:0] col_q;

	logic [AW-1:0]          lane_ang [2];
	logic [QW-1:0]          lane_q   [2];
	logic [WW-1:0]          lane_x   [2];
	logic [WW-1:0]          op_a     [2];
	logic [WW-1:0]          op_b     [2];
	logic [2*WW-1:0]        prod     [2];
	logic [WW-1:0]          prod_sh  [2];
	logic [WW:0]            r_inc    [2];
	logic [DW-1:0]          s_mag    [2];

	assign in_ready  = (st_q == ST_IDLE);
	assign ray_valid = (st_q == ST_PUSH);
	assign ray.dx     = dir_q[0];
	assign ray.dy     = dir_q[1];
	assign ray.column = col_q;

	// Fold each heading into the first quadrant: lane 0 is sin, lane 1 is cos
	assign lane_ang[0] = ray_angle;
	assign lane_ang[1] = ray_angle + QTR_A;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lane_q[l] = QW'(lane_ang[l][AW-3:0]);
			if (lane_ang[l][AW-2])
				lane_q[l] = QTR_Q - lane_q[l];
			lane_x[l] = WW'(lane_q[l]) << grm_pkg::X_SHIFT;
		end
	end

	// Select multiplier operands for the current polynomial phase
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			unique case (ph_q)
				PH_X2: begin
					op_a[l] = x_q[l];
					op_b[l] = x_q[l];
				end
				PH_T1: begin
					op_a[l] = C2320;
					op_b[l] = x2_q[l];
				end
				PH_T2: begin
					op_a[l] = t_q[l];
					op_b[l] = x2_q[l];
				end
				default: begin
					op_a[l] = x_q[l];
					op_b[l] = t_q[l];
				end
			endcase
			prod[l]    = op_a[l] * op_b[l];
			prod_sh[l] = prod[l][WW+14:15];
			r_inc[l]   = {1'b0, prod_sh[l]} + (WW+1)'(1);
			s_mag[l]   = DW'(r_inc[l][WW:1]);
		end
	end

	// Sequence: accept, four multiply phases, hand off to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_X2;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_CALC;
						ph_q <= PH_X2;
					end
				end
				ST_CALC: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == PH_R)
						st_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (ray_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Polynomial datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			col_q <= column;
			for (int l = 0; l < 2; l++) begin
				x_q[l]   <= lane_x[l];
				neg_q[l] <= lane_ang[l][AW-1];
			end
		end else if (st_q == ST_CALC) begin
			for (int l = 0; l < 2; l++) begin
				unique case (ph_q)
					PH_X2: x2_q[l] <= prod_sh[l];
					PH_T1: t_q[l]  <= C21024 - prod_sh[l];
					PH_T2: t_q[l]  <= C51472 - prod_sh[l];
					default: dir_q[l] <= neg_q[l] ? -$signed(s_mag[l]) : $signed(s_mag[l]);
				endcase
			end
		end
	end

endmodule

// ----- rtl/grm_fifo.sv -----
// Two-entry queue of rays between the front end and the marcher.
`timescale 1ns / 1ps
module grm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  grm_pkg::ray_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output grm_pkg::ray_t pop_data
);

	grm_pkg::ray_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Store a beat
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- rtl/grm_march.sv -----
// Back end: steps one ray through the grid and registers the result.
`timescale 1ns / 1ps
module grm_march (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ray_valid,
	output logic                              ray_ready,
	input  grm_pkg::ray_t                     ray,
	input  grm_pkg::cfg_t                     cfg,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [grm_pkg::COL_W-1:0]         out_column,
	output logic                              hit,
	output logic [grm_pkg::DIST_W-1:0]        distance,
	output logic [grm_pkg::SHADE_W-1:0]       shade
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_MARCH = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam int RW  = grm_pkg::REM_W;
	localparam int CW  = grm_pkg::CELL_W;
	localparam int DW  = grm_pkg::DIR_W;
	localparam int SW  = grm_pkg::STEP_W;
	localparam int LW  = grm_pkg::DIST_W;
	localparam int HW  = grm_pkg::SHADE_W;
	localparam int IW  = grm_pkg::MAP_IDX_W;
	localparam int XW  = grm_pkg::CX_W;

	localparam logic signed [RW-1:0] SPAN_R    = RW'(grm_pkg::SPAN);
	localparam logic signed [CW-1:0] MAP_DIM_C = CW'(grm_pkg::MAP_DIM);
	localparam logic [IW-1:0]        MAP_DIM_I = IW'(grm_pkg::MAP_DIM);
	localparam logic [SW-1:0]        MAX_K     = SW'(grm_pkg::MAX_STEPS);
	localparam logic [SW+LW-1:0]     DIST_MAX  = (SW+LW)'((1 << LW) - 1);
	localparam logic [HW-1:0]        SHADE_TOP = HW'((1 << HW) - 1);

	logic [1:0]             st_q;
	logic signed [DW-1:0]   dx_q;
	logic signed [DW-1:0]   dy_q;
	logic [grm_pkg::COL_W-1:0] col_q;
	logic signed [RW-1:0]   rem_x_q;
	logic signed [RW-1:0]   rem_y_q;
	logic signed [CW-1:0]   cell_x_q;
	logic signed [CW-1:0]   cell_y_q;
	logic [SW-1:0]          k_q;
	logic [1:0]             phase3_q;
	logic [HW-1:0]          shade_q;
	logic                   res_hit_q;
	logic [LW-1:0]          res_dist_q;
	logic [HW-1:0]          res_shade_q;
	logic                   out_valid_q;

	logic                   div_x;
	logic                   div_y;
	logic signed [RW-1:0]   sum_x;
	logic signed [RW-1:0]   sum_y;
	logic signed [RW-1:0]   nrem_x;
	logic signed [RW-1:0]   nrem_y;
	logic signed [CW-1:0]   ncell_x;
	logic signed [CW-1:0]   ncell_y;
	logic                   in_map;
	logic [IW-1:0]          map_idx;
	logic                   wall;
	logic [SW-1:0]          dist_k;
	logic [SW+LW-1:0]       dist_ext;
	logic [LW-1:0]          dist_sat;

	assign ray_ready  = (st_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	// Initial cell: subtract one cell span per cycle
	assign div_x = (rem_x_q >= SPAN_R);
	assign div_y = (rem_y_q >= SPAN_R);

	// One step: add direction, wrap remainder into the cell span
	always_comb begin
		sum_x   = rem_x_q + {{(RW-DW){dx_q[DW-1]}}, dx_q};
		sum_y   = rem_y_q + {{(RW-DW){dy_q[DW-1]}}, dy_q};
		nrem_x  = sum_x;
		ncell_x = cell_x_q;
		nrem_y  = sum_y;
		ncell_y = cell_y_q;
		priority if (sum_x >= SPAN_R) begin
			nrem_x  = sum_x - SPAN_R;
			ncell_x = cell_x_q + CW'(1);
		end else if (sum_x < 0) begin
			nrem_x  = sum_x + SPAN_R;
			ncell_x = cell_x_q - CW'(1);
		end
		priority if (sum_y >= SPAN_R) begin
			nrem_y  = sum_y - SPAN_R;
			ncell_y = cell_y_q + CW'(1);
		end else if (sum_y < 0) begin
			nrem_y  = sum_y + SPAN_R;
			ncell_y = cell_y_q - CW'(1);
		end
	end

	// Wall test on the current cell; cells off the map are empty
	assign in_map  = (cell_x_q >= 0) && (cell_x_q < MAP_DIM_C)
		&& (cell_y_q >= 0) && (cell_y_q < MAP_DIM_C);
	assign map_idx = IW'(cell_x_q[XW-1:0]) * MAP_DIM_I + IW'(cell_y_q[XW-1:0]);
	assign wall    = in_map && cfg.map[map_idx];

	// Distance is the step count before the hit, saturated to the field
	assign dist_k   = k_q - SW'(1);
	assign dist_ext = (SW+LW)'(dist_k);
	assign dist_sat = (dist_ext > DIST_MAX) ? DIST_MAX[LW-1:0] : dist_ext[LW-1:0];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid when a result is loaded, drop it once the beat is taken
			if (st_q == ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (ray_valid)
						st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_x && !div_y)
						st_q <= ST_MARCH;
				end
				ST_MARCH: begin
					if ((k_q != '0 && wall) || k_q == MAX_K)
						st_q <= ST_OUT;
				end
				default: begin
					if (!out_valid_q || out_ready)
						st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (ray_valid) begin
					dx_q     <= ray.dx;
					dy_q     <= ray.dy;
					col_q    <= ray.column;
					rem_x_q  <= RW'({cfg.pos_x, {grm_pkg::FX_SHIFT{1'b0}}});
					rem_y_q  <= RW'({cfg.pos_y, {grm_pkg::FX_SHIFT{1'b0}}});
					cell_x_q <= '0;
					cell_y_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_x) begin
					rem_x_q  <= rem_x_q - SPAN_R;
					cell_x_q <= cell_x_q + CW'(1);
				end
				if (div_y) begin
					rem_y_q  <= rem_y_q - SPAN_R;
					cell_y_q <= cell_y_q + CW'(1);
				end
				k_q      <= '0;
				phase3_q <= 2'd2;
				shade_q  <= SHADE_TOP;
			end
			ST_MARCH: begin
				priority if (k_q != '0 && wall) begin
					res_hit_q   <= 1'b1;
					res_dist_q  <= dist_sat;
					res_shade_q <= shade_q;
				end else if (k_q == MAX_K) begin
					res_hit_q   <= 1'b0;
					res_dist_q  <= '0;
					res_shade_q <= '0;
				end else begin
					rem_x_q  <= nrem_x;
					rem_y_q  <= nrem_y;
					cell_x_q <= ncell_x;
					cell_y_q <= ncell_y;
					k_q      <= k_q + SW'(1);
					// Track ceil(2d/3) as a residue mod 3, lower shade on each carry
					if (k_q != '0) begin
						if (phase3_q == 2'd0) begin
							phase3_q <= 2'd2;
						end else begin
							phase3_q <= phase3_q - 2'd1;
							if (shade_q != '0)
								shade_q <= shade_q - HW'(1);
						end
					end
				end
			end
			default: begin
				if (!out_valid_q || out_ready) begin
					out_column <= col_q;
					hit        <= res_hit_q;
					distance   <= res_dist_q;
					shade      <= res_shade_q;
				end
			end
		endcase
	end

endmodule

// ----- rtl/grid_ray_march_shader_core.sv -----
// Top level of the grid ray marcher: register file, front end, queue and marcher.
`timescale 1ns / 1ps
// Usage: write pos_x, pos_y, map_low and map_high over the cfg channel
// (cfg_index 0..3, cfg_data low bits) while no ray is in flight; cfg_ready
// is always high. Each beat on the in channel is one ray: a 12-bit binary
// heading and a column number. Each ray yields exactly one beat on the out
// channel, in order: the column, a hit flag, the step distance and a shade.
// The front end steps through each ray (accept, four multiply phases of the
// sin/cos polynomial, hand-off) and parks the direction vector in a
// two-entry queue. The marcher then loads the ray, finds the start cell by
// repeated subtraction of a 12800-unit cell span from pos_x and pos_y, takes
// one step per cycle plus a final check, at most MAX_STEPS steps, and then
// loads the output register.
// The marcher's step loop sets the sustained rate; the front end works
// ahead meanwhile.
// Reset clears all handshake state and loads pos_x = pos_y = 25600 and an
// empty map. A stalled out_ready holds the result; the marcher then waits
// with the next result, the queue fills, and in_ready drops after that.
module grid_ray_march_shader_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [grm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grm_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [grm_pkg::ANG_W-1:0]          ray_angle,
	input  logic [grm_pkg::COL_W-1:0]          column,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [grm_pkg::COL_W-1:0]          out_column,
	output logic                               hit,
	output logic [grm_pkg::DIST_W-1:0]         distance,
	output logic [grm_pkg::SHADE_W-1:0]        shade
);

	localparam logic [grm_pkg::POS_W-1:0] POS_RESET = grm_pkg::POS_W'(25600);

	logic [grm_pkg::POS_W-1:0]    pos_x_q;
	logic [grm_pkg::POS_W-1:0]    pos_y_q;
	logic [grm_pkg::MAP_LO_W-1:0] map_low_q;
	logic [grm_pkg::MAP_HI_W-1:0] map_high_q;
	grm_pkg::cfg_t                cfg;

	logic          f_valid;
	logic          f_ready;
	grm_pkg::ray_t f_ray;
	logic          q_valid;
	logic          q_ready;
	grm_pkg::ray_t q_ray;

	assign cfg_ready = 1'b1;
	assign cfg.pos_x = pos_x_q;
	assign cfg.pos_y = pos_y_q;
	assign cfg.map   = {map_high_q, map_low_q};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= POS_RESET;
			pos_y_q    <= POS_RESET;
			map_low_q  <= '0;
			map_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				grm_pkg::CFG_POS_X:   pos_x_q    <= cfg_data[grm_pkg::POS_W-1:0];
				grm_pkg::CFG_POS_Y:   pos_y_q    <= cfg_data[grm_pkg::POS_W-1:0];
				grm_pkg::CFG_MAP_LOW: map_low_q  <= cfg_data[grm_pkg::MAP_LO_W-1:0];
				default:              map_high_q <= cfg_data[grm_pkg::MAP_HI_W-1:0];
			endcase
		end
	end

	grm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ray_angle (ray_angle),
		.column    (column),
		.ray_valid (f_valid),
		.ray_ready (f_ready),
		.ray       (f_ray)
	);

	grm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_ray),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_ray)
	);

	grm_march u_march (
		.clk        (clk),
		.arst_n     (arst_n),
		.ray_valid  (q_valid),
		.ray_ready  (q_ready),
		.ray        (q_ray),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_column (out_column),
		.hit        (hit),
		.distance   (distance),
		.shade      (shade)
	);

endmodule
